FILE: rtl/scfs_pkg.sv
package scfs_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_SEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ASPECT  = 2'd2;

    localparam logic signed [31:0] ASPECT_RESET = 32'sd65536;
    localparam logic signed [31:0] SAT_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN      = 32'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [31:0] near_plane;
        logic signed [31:0] far_plane;
        logic signed [31:0] frustum_extent;
    } t_in;

    typedef struct packed {
        logic               eye_select;
        logic signed [31:0] shifted_eye_x;
        logic signed [31:0] shifted_eye_y;
        logic signed [31:0] shifted_eye_z;
        logic signed [31:0] shifted_target_x;
        logic signed [31:0] shifted_target_y;
        logic signed [31:0] shifted_target_z;
        logic signed [31:0] proj_m00;
        logic signed [31:0] proj_m02;
        logic signed [31:0] proj_m11;
        logic signed [31:0] proj_m22;
        logic signed [31:0] proj_m23;
    } t_out;

    // Request as queued for the back end, with the view vector and the plane
    // sum and difference already formed.
    typedef struct packed {
        t_in                item;
        logic signed [32:0] view_x;
        logic signed [32:0] view_y;
        logic signed [32:0] view_z;
        logic signed [32:0] plane_sum;
        logic signed [32:0] plane_diff;
    } t_job;

    typedef struct packed {
        logic        start;
        logic        long_div;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic        ovf;
        logic [31:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SQ,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_NDIV_GO,
        ST_NDIV_WAIT,
        ST_CROSS,
        ST_OFFS,
        ST_MUL,
        ST_PDIV_GO,
        ST_PDIV_WAIT,
        ST_EMIT_L,
        ST_EMIT_R
    } t_state;

endpackage

FILE: rtl/scfs_front.sv
module scfs_front
    import scfs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_job_valid,
    output t_job o_job,
    input  logic i_pop
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_job       n_job;
    logic       push;

    always_comb begin
        n_job            = '0;
        n_job.item       = i_in_data;
        n_job.view_x     = 33'(i_in_data.eye_x) - 33'(i_in_data.target_x);
        n_job.view_y     = 33'(i_in_data.eye_y) - 33'(i_in_data.target_y);
        n_job.view_z     = 33'(i_in_data.eye_z) - 33'(i_in_data.target_z);
        n_job.plane_sum  = 33'(i_in_data.near_plane) + 33'(i_in_data.far_plane);
        n_job.plane_diff = 33'(i_in_data.near_plane) - 33'(i_in_data.far_plane);
    end

    assign o_in_ready  = (r_cnt != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= n_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule

FILE: rtl/scfs_div.sv
module scfs_div
    import scfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_p;
    logic [63:0] r_n;
    logic [63:0] r_den;
    logic [31:0] r_q;
    logic        r_ovf;
    logic [64:0] pp;
    logic [64:0] diff;
    logic        ge;

    assign pp   = {r_p, r_n[63]};
    assign diff = pp - {1'b0, r_den};
    assign ge   = (pp >= {1'b0, r_den});

    assign o_rsp.done = r_done;
    assign o_rsp.ovf  = r_ovf;
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_den  <= i_req.den;
                r_q    <= '0;
                // A long division keeps 32 quotient bits; a quotient of 2^32
                // or more is flagged as overflow up front.
                if (i_req.long_div) begin
                    r_p   <= {32'h0, i_req.num[63:32]};
                    r_n   <= {i_req.num[31:0], 32'h0};
                    r_cnt <= 6'd32;
                    r_ovf <= ({32'h0, i_req.num[63:32]} >= i_req.den);
                end else begin
                    r_p   <= {17'h0, i_req.num[63:17]};
                    r_n   <= {i_req.num[16:0], 47'h0};
                    r_cnt <= 6'd17;
                    r_ovf <= 1'b0;
                end
            end else if (r_busy) begin
                r_p   <= ge ? diff[63:0] : pp[63:0];
                r_n   <= {r_n[62:0], 1'b0};
                r_q   <= {r_q[30:0], ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/scfs_sqrt.sv
module scfs_sqrt
    import scfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_x;
    logic [63:0] r_res;
    logic [63:0] bitv;
    logic [63:0] trial;

    assign bitv   = 64'd1 << {r_cnt, 1'b0};
    assign trial  = r_res + bitv;
    assign o_done = r_done;
    assign o_root = r_res[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_x    <= i_rad;
                r_res  <= '0;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/scfs_back.sv
module scfs_back
    import scfs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  t_job               i_job,
    output logic               o_pop,
    input  logic signed [31:0] i_overlap,
    input  logic signed [31:0] i_eye_sep,
    input  logic signed [31:0] i_aspect,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out               o_out_data
);

    t_state             r_state, n_state;
    t_job               r_job;
    logic               r_vsel;
    logic [1:0]         r_idx;
    logic [29:0]        r_mag [3];
    logic               r_neg [3];
    logic [63:0]        r_sum;
    logic [31:0]        r_len;
    logic signed [17:0] r_vn [3];
    logic signed [17:0] r_un [3];
    logic signed [20:0] r_a [3];
    logic signed [36:0] r_off [3];
    logic signed [63:0] r_ae;
    logic [63:0]        r_nfm;
    logic signed [31:0] r_m [4];
    logic               r_nneg, r_dneg, r_dzero, r_nzero;
    logic               r_out_valid;
    t_out               r_out;

    logic signed [32:0] src [3];
    logic [32:0]        mag [3];
    logic [32:0]        orm;
    logic [1:0]         shamt;
    logic [59:0]        sq;
    logic signed [17:0] ca, cb, cc, cd;
    logic signed [35:0] p1, p2;
    logic signed [36:0] cdiff;
    logic signed [52:0] oprod;
    logic [31:0]        near_mag, far_mag;
    logic [32:0]        nf_mag;
    logic [63:0]        pnum;
    logic signed [63:0] pden;
    logic               pnneg;
    logic [63:0]        pden_mag;
    logic signed [17:0] nval;
    logic signed [31:0] dres;
    logic [31:0]        q;
    logic               qneg;
    logic               load_out;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    t_div_req           div_req;
    t_div_rsp           div_rsp;
    t_out               res_l, res_r;
    logic signed [33:0] ov2;

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        logic signed [31:0] r;
        if (v > 38'sd2147483647) begin
            r = SAT_MAX;
        end else if (v < -38'sd2147483648) begin
            r = SAT_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    scfs_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_rad   (r_sum),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    scfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Magnitudes of the vector being normalised, scaled so that all three
    // fit in 30 bits.
    always_comb begin
        if (!r_vsel) begin
            src[0] = r_job.view_x;
            src[1] = r_job.view_y;
            src[2] = r_job.view_z;
        end else begin
            src[0] = 33'(r_job.item.up_x);
            src[1] = 33'(r_job.item.up_y);
            src[2] = 33'(r_job.item.up_z);
        end
        for (int i = 0; i < 3; i++) begin
            mag[i] = src[i][32] ? 33'(-src[i]) : 33'(src[i]);
        end
        orm = mag[0] | mag[1] | mag[2];
        if (orm[32]) begin
            shamt = 2'd3;
        end else if (orm[31]) begin
            shamt = 2'd2;
        end else if (orm[30]) begin
            shamt = 2'd1;
        end else begin
            shamt = 2'd0;
        end
    end

    assign sq = r_mag[r_idx] * r_mag[r_idx];

    always_comb begin
        case (r_idx)
            2'd0: begin
                ca = r_un[1]; cb = r_vn[2]; cc = r_un[2]; cd = r_vn[1];
            end
            2'd1: begin
                ca = r_un[2]; cb = r_vn[0]; cc = r_un[0]; cd = r_vn[2];
            end
            default: begin
                ca = r_un[0]; cb = r_vn[1]; cc = r_un[1]; cd = r_vn[0];
            end
        endcase
    end

    assign p1    = ca * cb;
    assign p2    = cc * cd;
    assign cdiff = 37'(p1) - 37'(p2);
    assign oprod = 53'(i_eye_sep) * 53'(r_a[r_idx]);

    assign near_mag = r_job.item.near_plane[31] ? 32'(-r_job.item.near_plane)
                                                : 32'(r_job.item.near_plane);
    assign far_mag  = r_job.item.far_plane[31] ? 32'(-r_job.item.far_plane)
                                               : 32'(r_job.item.far_plane);
    assign nf_mag   = r_job.plane_sum[32] ? 33'(-r_job.plane_sum)
                                          : 33'(r_job.plane_sum);

    always_comb begin
        case (r_idx)
            2'd0: begin
                pnum  = 64'd1 << 33;
                pnneg = 1'b0;
                pden  = 64'(r_job.item.frustum_extent);
            end
            2'd1: begin
                pnum  = 64'd1 << 49;
                pnneg = 1'b0;
                pden  = r_ae;
            end
            2'd2: begin
                pnum  = {15'h0, nf_mag, 16'h0};
                pnneg = r_job.plane_sum[32];
                pden  = 64'(r_job.plane_diff);
            end
            default: begin
                pnum  = {r_nfm[62:0], 1'b0};
                pnneg = r_job.item.near_plane[31] ^ r_job.item.far_plane[31];
                pden  = 64'(r_job.plane_diff);
            end
        endcase
        pden_mag = pden[63] ? 64'(-pden) : 64'(pden);
    end

    // Signed normalised component; a zero length yields zero.
    always_comb begin
        if (r_len == 32'd0) begin
            nval = '0;
        end else begin
            nval = {1'b0, div_rsp.quot[16:0]};
        end
        if (r_neg[r_idx]) begin
            nval = -nval;
        end
    end

    // Saturating result of a projection division.
    always_comb begin
        q    = div_rsp.quot;
        qneg = r_nneg ^ r_dneg;
        if (r_dzero) begin
            dres = r_nzero ? 32'sd0 : (r_nneg ? SAT_MIN : SAT_MAX);
        end else if (div_rsp.ovf) begin
            dres = qneg ? SAT_MIN : SAT_MAX;
        end else if (qneg) begin
            dres = (q > 32'h8000_0000) ? SAT_MIN : $signed(-q);
        end else begin
            dres = (q > 32'h7FFF_FFFF) ? SAT_MAX : $signed(q);
        end
    end

    always_comb begin
        ov2 = {i_overlap[31], i_overlap, 1'b0};
        res_l.eye_select       = 1'b0;
        res_l.shifted_eye_x    = sat32(38'(r_job.item.eye_x) - 38'(r_off[0]));
        res_l.shifted_eye_y    = sat32(38'(r_job.item.eye_y) - 38'(r_off[1]));
        res_l.shifted_eye_z    = sat32(38'(r_job.item.eye_z) - 38'(r_off[2]));
        res_l.shifted_target_x = sat32(38'(r_job.item.target_x) - 38'(r_off[0]));
        res_l.shifted_target_y = sat32(38'(r_job.item.target_y) - 38'(r_off[1]));
        res_l.shifted_target_z = sat32(38'(r_job.item.target_z) - 38'(r_off[2]));
        res_l.proj_m00         = r_m[0];
        res_l.proj_m11         = r_m[1];
        res_l.proj_m22         = r_m[2];
        res_l.proj_m23         = r_m[3];
        res_r                  = res_l;
        res_r.eye_select       = 1'b1;
        res_r.shifted_eye_x    = sat32(38'(r_job.item.eye_x) + 38'(r_off[0]));
        res_r.shifted_eye_y    = sat32(38'(r_job.item.eye_y) + 38'(r_off[1]));
        res_r.shifted_eye_z    = sat32(38'(r_job.item.eye_z) + 38'(r_off[2]));
        res_r.shifted_target_x = sat32(38'(r_job.item.target_x) + 38'(r_off[0]));
        res_r.shifted_target_y = sat32(38'(r_job.item.target_y) + 38'(r_off[1]));
        res_r.shifted_target_z = sat32(38'(r_job.item.target_z) + 38'(r_off[2]));
        if (r_job.item.frustum_extent == 32'sd0) begin
            res_l.proj_m02 = '0;
            res_r.proj_m02 = '0;
        end else begin
            res_l.proj_m02 = sat32(38'(ov2 - 34'sd65536));
            res_r.proj_m02 = sat32(38'(34'sd65536 - ov2));
        end
    end

    always_comb begin
        n_state        = r_state;
        o_pop          = 1'b0;
        sqrt_start     = 1'b0;
        div_req        = '0;
        load_out       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    o_pop   = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = ST_SQ;
            ST_SQ: begin
                if (r_idx == 2'd2) begin
                    n_state = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                n_state    = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = ST_NDIV_GO;
                end
            end
            ST_NDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.long_div = 1'b0;
                div_req.num      = {18'h0, r_mag[r_idx], 16'h0};
                div_req.den      = {32'h0, r_len};
                n_state          = ST_NDIV_WAIT;
            end
            ST_NDIV_WAIT: begin
                if (div_rsp.done) begin
                    if (r_idx != 2'd2) begin
                        n_state = ST_NDIV_GO;
                    end else if (!r_vsel) begin
                        n_state = ST_PREP;
                    end else begin
                        n_state = ST_CROSS;
                    end
                end
            end
            ST_CROSS: begin
                if (r_idx == 2'd2) begin
                    n_state = ST_OFFS;
                end
            end
            ST_OFFS: begin
                if (r_idx == 2'd2) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_idx == 2'd1) begin
                    n_state = ST_PDIV_GO;
                end
            end
            ST_PDIV_GO: begin
                div_req.start    = 1'b1;
                div_req.long_div = 1'b1;
                div_req.num      = pnum;
                div_req.den      = pden_mag;
                n_state          = ST_PDIV_WAIT;
            end
            ST_PDIV_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_idx == 2'd3) ? ST_EMIT_L : ST_PDIV_GO;
                end
            end
            ST_EMIT_L: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_EMIT_R;
                end
            end
            ST_EMIT_R: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
            r_vsel      <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out       <= (r_state == ST_EMIT_L) ? res_l : res_r;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    r_job  <= i_job;
                    r_vsel <= 1'b0;
                end
                ST_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= 30'(mag[i] >> shamt);
                        r_neg[i] <= src[i][32];
                    end
                    r_sum <= '0;
                    r_idx <= 2'd0;
                end
                ST_SQ: begin
                    r_sum <= r_sum + {4'h0, sq};
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_len <= sqrt_root;
                    end
                end
                ST_NDIV_WAIT: begin
                    if (div_rsp.done) begin
                        if (!r_vsel) begin
                            r_vn[r_idx] <= nval;
                        end else begin
                            r_un[r_idx] <= nval;
                        end
                        if (r_idx == 2'd2) begin
                            r_idx  <= 2'd0;
                            r_vsel <= 1'b1;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                ST_CROSS: begin
                    r_a[r_idx] <= cdiff[36:16];
                    r_idx      <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                ST_OFFS: begin
                    r_off[r_idx] <= oprod[52:16];
                    r_idx        <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                ST_MUL: begin
                    if (r_idx == 2'd0) begin
                        r_ae  <= 64'(i_aspect) * 64'(r_job.item.frustum_extent);
                        r_idx <= 2'd1;
                    end else begin
                        r_nfm <= 64'(near_mag) * 64'(far_mag);
                        r_idx <= 2'd0;
                    end
                end
                ST_PDIV_GO: begin
                    r_nneg  <= pnneg;
                    r_dneg  <= pden[63];
                    r_dzero <= (pden == 64'sd0);
                    r_nzero <= (pnum == 64'd0);
                end
                ST_PDIV_WAIT: begin
                    if (div_rsp.done) begin
                        r_m[r_idx] <= dres;
                        r_idx      <= r_idx + 2'd1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/stereo_camera_frustum_setup_top.sv
// The left-eye result is produced once the back end has finished a request; the right-eye
// result follows once the left one is taken.
// The back end works on one camera at a time, at a pace set by the shared bit-serial
// divider (six divisions with 17 quotient bits and four with 32) and the 32-bit root.
// A two-entry queue takes new requests while the back end works.
// Reset is synchronous and active low; it empties the queue and the output
// register and loads overlap 0, eye separation 0 and aspect 1.0.
module stereo_camera_frustum_setup_top
    import scfs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    logic signed [31:0] r_overlap;
    logic signed [31:0] r_eye_sep;
    logic signed [31:0] r_aspect;
    logic               job_valid;
    t_job               job;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overlap <= '0;
            r_eye_sep <= '0;
            r_aspect  <= ASPECT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OVERLAP: r_overlap <= i_cfg_data;
                CFG_EYE_SEP: r_eye_sep <= i_cfg_data;
                CFG_ASPECT:  r_aspect  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    scfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_pop       (pop)
    );

    scfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_pop       (pop),
        .i_overlap   (r_overlap),
        .i_eye_sep   (r_eye_sep),
        .i_aspect    (r_aspect),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // The right eye is loaded in the very cycle its left partner is taken.
    a_right_follows_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.eye_select
        |=> o_out_valid && o_out_data.eye_select)
        else $error("right-eye result did not follow the left-eye result");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset left a result pending or the queue full");

endmodule
